@@ rtl/arbcd_pkg.sv @@
package arbcd_pkg;

  // Register indexes on the configuration channel
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t RegDigitCount    = 2'd0;
  localparam reg_idx_t RegResolution    = 2'd1;
  localparam reg_idx_t RegInvResolution = 2'd2;

  // Request actions
  localparam logic ActEncode = 1'b0;
  localparam logic ActDecode = 1'b1;

  // Register reset values
  localparam logic [2:0]  DigitCountReset    = 3'd5;
  localparam logic [31:0] ResolutionReset    = 32'h0001_0000;
  localparam logic [31:0] InvResolutionReset = 32'h0001_0000;

  // Widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 18;  // saturated count, at most 199999
  localparam int unsigned SumW   = 19;  // decoded digit sum, at most 266665
  localparam int unsigned ValueW = 52;  // signed Q35.16

  // Decimal weights of the digit positions, lowest first
  localparam logic [16:0] Pow10 [6] = '{17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000,
                                        17'd100000};

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [2:0]       digits;          // effective digit count, 1..6
    logic             six;             // six-digit layout
    logic [WordW-1:0] resolution;
    logic [WordW-1:0] inv_resolution;
  } cfg_t;

  // Request leaving the arithmetic front end
  typedef struct packed {
    logic              action;
    logic [WordW-1:0]  word;
    logic              overflow;
    logic [CountW-1:0] count;
    logic [ValueW-1:0] value;
  } front_t;

  // Bit position of the lowest digit in the word
  function automatic logic [4:0] field_lsb(input logic [2:0] n);
    logic [4:0] lsb;
    case (n)
      3'd1:    lsb = 5'd26;
      3'd2:    lsb = 5'd22;
      3'd3:    lsb = 5'd18;
      3'd4:    lsb = 5'd14;
      3'd5:    lsb = 5'd10;
      default: lsb = 5'd8;
    endcase
    return lsb;
  endfunction

  // Bits of the word kept when the digit field is rewritten
  function automatic logic [WordW-1:0] keep_mask(input logic [2:0] n);
    logic [WordW-1:0] m;
    case (n)
      3'd1:    m = 32'he3ff_ffff;
      3'd2:    m = 32'he03f_ffff;
      3'd3:    m = 32'he003_ffff;
      3'd4:    m = 32'he000_3fff;
      3'd5:    m = 32'he000_03ff;
      default: m = 32'he000_00ff;
    endcase
    return m;
  endfunction

  // Largest count the field can hold
  function automatic logic [CountW-1:0] max_count(input logic [2:0] n);
    logic [CountW-1:0] c;
    case (n)
      3'd1:    c = 18'd7;
      3'd2:    c = 18'd79;
      3'd3:    c = 18'd799;
      3'd4:    c = 18'd7999;
      3'd5:    c = 18'd79999;
      default: c = 18'd199999;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/arbcd_if.sv @@
// Request channel: one ARINC word and one value per request
interface arbcd_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [31:0]        word_in;
  logic signed [31:0] value_in;

  modport source (output valid, action, word_in, value_in, input ready);
  modport sink   (input valid, action, word_in, value_in, output ready);
endinterface

// Result channel
interface arbcd_res_if;
  logic               valid;
  logic               ready;
  logic [31:0]        word_out;
  logic signed [51:0] value_out;
  logic               overflow;

  modport source (output valid, word_out, value_out, overflow, input ready);
  modport sink   (input valid, word_out, value_out, overflow, output ready);
endinterface

// Configuration write channel
interface arbcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/arbcd_front.sv @@
module arbcd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arbcd_pkg::cfg_t    cfg_i,
  arbcd_req_if.sink          req_i,
  output logic               valid_o,
  input  logic               ready_i,
  output arbcd_pkg::front_t  data_o
);

  // Stage 1: scaled count or digit sum
  logic                             s1_valid_q;
  logic                             s1_action_q;
  logic [arbcd_pkg::WordW-1:0]      s1_word_q;
  logic [arbcd_pkg::WordW-1:0]      s1_raw_q;
  logic [arbcd_pkg::SumW-1:0]       s1_sum_q;
  // Stage 2: saturated count or scaled value
  logic                             s2_valid_q;
  arbcd_pkg::front_t                s2_q, s2_d;

  logic                             en1, en2;
  logic [31:0]                      vin, mag;
  logic [63:0]                      prod;
  logic [arbcd_pkg::WordW-1:0]      raw_d;
  logic [arbcd_pkg::WordW-1:0]      aligned;
  logic [3:0]                       nib;
  logic [arbcd_pkg::SumW-1:0]       sum_d;
  logic                             over;
  logic [50:0]                      scaled;

  // Stall chain: a stage loads when empty or when its content moves on
  assign en2         = !s2_valid_q || ready_i;
  assign en1         = !s1_valid_q || en2;
  assign req_i.ready = en1;

  // Magnitude times inverse resolution; plain integer part when the resolution is zero
  assign vin  = req_i.value_in;
  assign mag  = vin[31] ? (~vin + 32'd1) : vin;
  assign prod = 64'(mag) * 64'(cfg_i.inv_resolution);
  assign raw_d = (cfg_i.resolution != '0) ? prod[63:32] : {16'd0, mag[31:16]};

  // Weighted sum of the digit fields
  assign aligned = req_i.word_in >> arbcd_pkg::field_lsb(cfg_i.digits);
  always_comb begin
    sum_d = '0;
    nib   = '0;
    for (int p = 0; p < 6; p++) begin
      nib = aligned[4*p +: 4];
      if (3'(p) >= cfg_i.digits) begin
        nib = '0;
      end else if (3'(p) == cfg_i.digits - 3'd1) begin
        nib = nib & (cfg_i.six ? 4'b0001 : 4'b0111);
      end
      sum_d = sum_d + arbcd_pkg::SumW'(nib) * arbcd_pkg::SumW'(arbcd_pkg::Pow10[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_action_q <= req_i.action;
      s1_word_q   <= req_i.word_in;
      s1_raw_q    <= raw_d;
      s1_sum_q    <= sum_d;
    end
  end

  // Saturation on encode, resolution scaling on decode
  assign over   = s1_raw_q > arbcd_pkg::WordW'(arbcd_pkg::max_count(cfg_i.digits));
  assign scaled = (cfg_i.resolution != '0)
                ? 51'(s1_sum_q) * 51'(cfg_i.resolution)
                : 51'(s1_sum_q) << 16;

  always_comb begin
    s2_d.action = s1_action_q;
    s2_d.word   = s1_word_q;
    if (s1_action_q == arbcd_pkg::ActEncode) begin
      s2_d.overflow = over;
      s2_d.count    = over ? arbcd_pkg::max_count(cfg_i.digits)
                           : s1_raw_q[arbcd_pkg::CountW-1:0];
      s2_d.value    = '0;
    end else begin
      s2_d.overflow = 1'b0;
      s2_d.count    = '0;
      s2_d.value    = arbcd_pkg::ValueW'(scaled);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_q;

endmodule

@@ rtl/arbcd_digits.sv @@
module arbcd_digits (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arbcd_pkg::cfg_t    cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  arbcd_pkg::front_t  data_i,
  arbcd_res_if.source        res_o
);

  // Reciprocal constants: exact over the value ranges used here
  localparam logic [18:0] Recip1000 = 19'd268436;  // 2^28 / 1000, rounded up
  localparam logic [5:0]  Recip100  = 6'd41;       // 2^12 / 100, rounded up
  localparam logic [7:0]  Recip10   = 8'd205;      // 2^11 / 10, rounded up

  // Stage 3: thousands split, sign applied
  logic                         s3_valid_q;
  logic                         s3_action_q;
  logic [31:0]                  s3_word_q;
  logic                         s3_ovf_q;
  logic [7:0]                   s3_hi_q;
  logic [9:0]                   s3_lo_q;
  logic [51:0]                  s3_value_q;
  // Stage 4: hundreds digits and remainders
  logic                         s4_valid_q;
  logic                         s4_action_q;
  logic [31:0]                  s4_word_q;
  logic                         s4_ovf_q;
  logic [3:0]                   s4_hi_h_q, s4_lo_h_q;
  logic [6:0]                   s4_hi_r_q, s4_lo_r_q;
  logic [51:0]                  s4_value_q;
  // Stage 5: output register
  logic                         s5_valid_q;
  logic [31:0]                  s5_word_q, s5_word_d;
  logic                         s5_ovf_q;
  logic [51:0]                  s5_value_q;

  logic                         en3, en4, en5;
  logic [36:0]                  hprod;
  logic [7:0]                   hi_d;
  logic [9:0]                   lo_d;
  logic [51:0]                  value_d;
  logic [15:0]                  hi_hq, lo_hq;
  logic [3:0]                   hi_h_d, lo_h_d;
  logic [6:0]                   hi_r_d, lo_r_d;
  logic [14:0]                  hi_tq, lo_tq;
  logic [3:0]                   hi_t, hi_u, lo_t, lo_u;
  logic [23:0]                  bcd;
  logic [31:0]                  placed, keep;

  assign en5     = !s5_valid_q || res_o.ready;
  assign en4     = !s4_valid_q || en5;
  assign en3     = !s3_valid_q || en4;
  assign ready_o = en3;

  // Count split into thousands and remainder
  assign hprod = 37'(data_i.count) * 37'(Recip1000);
  assign hi_d  = hprod[35:28];
  assign lo_d  = 10'(data_i.count - arbcd_pkg::CountW'(hi_d) * arbcd_pkg::CountW'(1000));

  // Negate when SSM is 11
  assign value_d = (data_i.word[30:29] == 2'b11) ? (52'd0 - data_i.value) : data_i.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en3) begin
      s3_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_action_q <= data_i.action;
      s3_word_q   <= data_i.word;
      s3_ovf_q    <= data_i.overflow;
      s3_hi_q     <= hi_d;
      s3_lo_q     <= lo_d;
      s3_value_q  <= (data_i.action == arbcd_pkg::ActDecode) ? value_d : '0;
    end
  end

  // Hundreds digit of each three-digit half
  assign hi_hq  = 16'(s3_hi_q) * 16'(Recip100);
  assign hi_h_d = hi_hq[15:12];
  assign hi_r_d = 7'(10'(s3_hi_q) - 10'(hi_h_d) * 10'd100);
  assign lo_hq  = 16'(s3_lo_q) * 16'(Recip100);
  assign lo_h_d = lo_hq[15:12];
  assign lo_r_d = 7'(s3_lo_q - 10'(lo_h_d) * 10'd100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en4) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_action_q <= s3_action_q;
      s4_word_q   <= s3_word_q;
      s4_ovf_q    <= s3_ovf_q;
      s4_hi_h_q   <= hi_h_d;
      s4_hi_r_q   <= hi_r_d;
      s4_lo_h_q   <= lo_h_d;
      s4_lo_r_q   <= lo_r_d;
      s4_value_q  <= s3_value_q;
    end
  end

  // Tens and units, then the digit field is written into the word
  assign hi_tq = 15'(s4_hi_r_q) * 15'(Recip10);
  assign hi_t  = hi_tq[14:11];
  assign hi_u  = 4'(s4_hi_r_q - 7'(hi_t) * 7'd10);
  assign lo_tq = 15'(s4_lo_r_q) * 15'(Recip10);
  assign lo_t  = lo_tq[14:11];
  assign lo_u  = 4'(s4_lo_r_q - 7'(lo_t) * 7'd10);

  assign bcd    = {s4_hi_h_q, hi_t, hi_u, s4_lo_h_q, lo_t, lo_u};
  assign placed = 32'(bcd) << arbcd_pkg::field_lsb(cfg_i.digits);
  assign keep   = arbcd_pkg::keep_mask(cfg_i.digits);

  assign s5_word_d = (s4_action_q == arbcd_pkg::ActEncode)
                   ? ((s4_word_q & keep) | (placed & ~keep))
                   : s4_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en5) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_word_q  <= s5_word_d;
      s5_ovf_q   <= s4_ovf_q;
      s5_value_q <= s4_value_q;
    end
  end

  assign res_o.valid     = s5_valid_q;
  assign res_o.word_out  = s5_word_q;
  assign res_o.value_out = s5_value_q;
  assign res_o.overflow  = s5_ovf_q;

endmodule

@@ rtl/arinc429_bcd_field_codec.sv @@
// ARINC 429 BCD field codec. Each request on req_i either packs a signed
// Q16.16 value into the BCD digit field of a 32-bit word (action 0) or
// unpacks that field into a signed Q35.16 value (action 1); every request
// yields exactly one result on res_o, in order. The block is a five-stage
// pipeline that takes one request per clock; the stages are the 32x32
// scaling multiply, the saturation and resolution multiply, and three
// stages of decimal digit extraction. A stall on res_o holds the pipeline
// in place, and empty stages still fill while it waits. Configuration
// writes on cfg_i are always accepted and must only be made while no
// request is in flight.
module arinc429_bcd_field_codec (
  input  logic  clk_i,
  input  logic  rst_ni,
  arbcd_cfg_if.sink   cfg_i,
  arbcd_req_if.sink   req_i,
  arbcd_res_if.source res_o
);

  logic [2:0]        digit_count_q;
  logic [31:0]       resolution_q;
  logic [31:0]       inv_resolution_q;
  arbcd_pkg::cfg_t   cfg;
  logic              mid_valid, mid_ready;
  arbcd_pkg::front_t mid_data;

  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q    <= arbcd_pkg::DigitCountReset;
      resolution_q     <= arbcd_pkg::ResolutionReset;
      inv_resolution_q <= arbcd_pkg::InvResolutionReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        arbcd_pkg::RegDigitCount:    digit_count_q    <= cfg_i.data[2:0];
        arbcd_pkg::RegResolution:    resolution_q     <= cfg_i.data;
        arbcd_pkg::RegInvResolution: inv_resolution_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Effective digit count: zero reads as one, seven as six
  always_comb begin
    case (digit_count_q)
      3'd0:    cfg.digits = 3'd1;
      3'd7:    cfg.digits = 3'd6;
      default: cfg.digits = digit_count_q;
    endcase
    cfg.six            = (cfg.digits == 3'd6);
    cfg.resolution     = resolution_q;
    cfg.inv_resolution = inv_resolution_q;
  end

  arbcd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .req_i   (req_i),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid_data)
  );

  arbcd_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (mid_data),
    .res_o   (res_o)
  );

endmodule

@@ test/tb_arinc429_bcd_field_codec.sv @@
module tb_arinc429_bcd_field_codec;
  timeunit 1ns;
  timeprecision 1ps;

  import arbcd_pkg::*;

  // Index that no register answers to
  localparam reg_idx_t RegUnused = 2'd3;

  typedef struct packed {
    logic        action;
    logic [31:0] word;
    logic [31:0] value;
  } codec_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [51:0] value;
    logic        overflow;
  } codec_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  arbcd_cfg_if cfg_if ();
  arbcd_req_if req_if ();
  arbcd_res_if res_if ();

  arinc429_bcd_field_codec u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the codec settings
  logic [2:0]  shadow_digits = DigitCountReset;
  logic [31:0] shadow_res    = ResolutionReset;
  logic [31:0] shadow_inv    = InvResolutionReset;

  codec_req_t  queued_words[$];
  codec_res_t  due_results[$];
  codec_req_t  on_bus;
  codec_res_t  oldest_due;
  int unsigned n_queued    = 0;
  int unsigned n_accepted  = 0;
  int unsigned mismatches  = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  bit          sender_calm = 1'b0;
  bit          sink_calm   = 1'b0;

  task automatic log_mismatch(string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Packs or unpacks the digit field under the shadow settings
  function automatic codec_res_t convert_field(codec_req_t rq);
    codec_res_t      res;
    int unsigned     n, k, lsb, width;
    logic [31:0]     word, mag, fmask, dig;
    longint unsigned count, limit, weight, sum, val;
    res = '0;
    word = rq.word;
    count = 0;
    sum = 0;
    // digit count zero reads as one, seven as six
    n = (shadow_digits == 3'd0) ? 1 : (shadow_digits == 3'd7) ? 6 : shadow_digits;
    if (rq.action == ActEncode) begin
      mag = rq.value[31] ? 32'd0 - rq.value : rq.value;
      // zero resolution: plain integer part; zero inverse gives count 0
      if (shadow_res != 32'd0) count = (64'(mag) * 64'(shadow_inv)) >> 32;
      else count = 64'(mag >> 16);
      if (n == 6) begin
        limit = 64'd199999;
      end else begin
        limit = 1;
        repeat (n - 1) limit *= 10;
        limit = 8 * limit - 1;
      end
      if (count > limit) begin
        count = limit;
        res.overflow = 1'b1;
      end
    end
    for (k = 0; k < n; k++) begin
      lsb = (n == 6) ? 28 - 4 * k : 26 - 4 * k;
      width = (k != 0) ? 4 : (n == 6) ? 1 : 3;
      weight = 1;
      repeat (n - 1 - k) weight *= 10;
      fmask = ((32'd1 << width) - 32'd1) << lsb;
      if (rq.action == ActEncode) begin
        dig = 32'((count / weight) % 10);
        word = (word & ~fmask) | ((dig << lsb) & fmask);
      end else begin
        // nibbles above nine are weighted as read
        sum += 64'((word & fmask) >> lsb) * weight;
      end
    end
    res.word = word;
    if (rq.action == ActDecode) begin
      val = (shadow_res != 32'd0) ? sum * 64'(shadow_res) : sum << 16;
      if (word[30:29] == 2'b11) val = 64'd0 - val;
      res.value = val[51:0];
    end
    return res;
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        due_results.push_back(convert_field(on_bus));
        n_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (queued_words.size() != 0) begin
          on_bus = queued_words.pop_front();
          req_if.valid    <= 1'b1;
          req_if.action   <= on_bus.action;
          req_if.word_in  <= on_bus.word;
          req_if.value_in <= on_bus.value;
          if (!sender_calm) send_gap = draw_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          log_mismatch($sformatf("result %h with nothing outstanding", res_if.word_out));
        end else begin
          oldest_due = due_results.pop_front();
          if (res_if.word_out !== oldest_due.word)
            log_mismatch($sformatf("word_out %h, expected %h",
                                   res_if.word_out, oldest_due.word));
          if (res_if.value_out !== oldest_due.value)
            log_mismatch($sformatf("value_out %h, expected %h",
                                   res_if.value_out, oldest_due.value));
          if (res_if.overflow !== oldest_due.overflow)
            log_mismatch($sformatf("overflow %b, expected %b",
                                   res_if.overflow, oldest_due.overflow));
        end
      end
      if (stall_left == 0 && !sink_calm) stall_left = draw_gap();
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_register(reg_idx_t idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      RegDigitCount:    shadow_digits = data[2:0];
      RegResolution:    shadow_res    = data;
      RegInvResolution: shadow_inv    = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [31:0] digits, logic [31:0] res, logic [31:0] inv);
    write_register(RegDigitCount, digits);
    write_register(RegResolution, res);
    write_register(RegInvResolution, inv);
  endtask

  task automatic queue_request(logic action, logic [31:0] word, logic [31:0] value);
    queued_words.push_back('{action: action, word: word, value: value});
    n_queued++;
  endtask

  // Zero, full scale, or a random value spread over all magnitudes
  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic codec_req_t random_request();
    codec_req_t  rq;
    logic [31:0] v;
    int unsigned k, base, nibbles;
    rq.action = $urandom_range(0, 1);
    rq.word = $urandom;
    // half the decodes carry proper BCD digits below the top digit of a five- or six-digit field
    if (rq.action == ActDecode && $urandom_range(0, 1) == 0) begin
      base = (shadow_digits >= 3'd6) ? 8 : 10;
      nibbles = (shadow_digits >= 3'd6) ? 5 : 4;
      for (k = 0; k < nibbles; k++) rq.word[base + 4 * k +: 4] = $urandom_range(0, 9);
    end
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'd0;
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
      end
    endcase
    rq.value = v;
    return rq;
  endfunction

  task automatic run_random(int unsigned count);
    sender_calm = ($urandom_range(0, 3) == 0);
    sink_calm   = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      queued_words.push_back(random_request());
      n_queued++;
    end
  endtask

  // Sender holds off until every result is back, then the pipe empties
  task automatic settle();
    while (n_accepted != n_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] res;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = RegDigitCount;
    cfg_if.data     = '0;
    req_if.valid    = 1'b0;
    req_if.action   = ActEncode;
    req_if.word_in  = '0;
    req_if.value_in = '0;
    res_if.ready    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: five digits, unit scale
    queue_request(ActEncode, 32'h0000_0000, 32'h0000_0000);
    queue_request(ActEncode, 32'hffff_ffff, 32'h7fff_ffff);
    queue_request(ActEncode, 32'h0000_0000, 32'h8000_0000);
    queue_request(ActEncode, 32'ha5a5_a5a5, 32'hffff_ffff);
    queue_request(ActDecode, 32'hffff_ffff, 32'h0000_0000);
    queue_request(ActDecode, 32'h0000_0000, 32'hffff_ffff);
    queue_request(ActDecode, 32'h2000_0000, 32'h0000_0000);
    queue_request(ActDecode, 32'h4000_0000, 32'h0000_0000);
    queue_request(ActDecode, 32'h6000_0000, 32'h0000_0000);
    queue_request(ActDecode, 32'h7e66_6400, 32'h0000_0000);
    run_random(30);
    settle();

    // Six digits, zero resolution means unit scaling
    apply_settings(32'd6, 32'd0, 32'd0);
    queue_request(ActEncode, 32'h0000_0000, 32'h7fff_ffff);
    queue_request(ActEncode, 32'hffff_ffff, 32'h8000_0000);
    queue_request(ActDecode, 32'hffff_ffff, 32'h0000_0000);
    queue_request(ActDecode, 32'h1999_9900, 32'h0000_0000);
    run_random(35);
    settle();

    // Digit count zero, full-scale resolution with zero inverse
    apply_settings(32'hffff_fff8, 32'hffff_ffff, 32'd0);
    queue_request(ActEncode, 32'hffff_ffff, 32'h7fff_ffff);
    queue_request(ActDecode, 32'hffff_ffff, 32'h0000_0000);
    run_random(35);
    settle();

    // Digit count seven, tiny resolution with full-scale inverse
    apply_settings(32'd7, 32'd1, 32'hffff_ffff);
    queue_request(ActEncode, 32'h0000_0000, 32'h8000_0000);
    queue_request(ActEncode, 32'hffff_ffff, 32'h0000_0001);
    run_random(35);
    settle();

    // A write to no register, then one digit at half resolution
    write_register(RegUnused, $urandom);
    apply_settings(32'd1, 32'h0000_8000, 32'h0002_0000);
    queue_request(ActEncode, 32'h0000_0000, 32'h0004_0000);
    queue_request(ActEncode, 32'h0000_0000, 32'h0003_8000);
    queue_request(ActDecode, 32'h1c00_0000, 32'h0000_0000);
    run_random(35);
    settle();

    // Random settings, often with a matching reciprocal
    repeat (9) begin
      res = pick_scale();
      apply_settings($urandom, res,
                     ($urandom_range(0, 1) == 1 && res != 32'd0) ?
                       32'((64'd1 << 32) / res) : pick_scale());
      run_random(40);
      settle();
    end

    if (mismatches == 0) $display("tb_arinc429_bcd_field_codec: done, clean");
    else $display("tb_arinc429_bcd_field_codec: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("tb_arinc429_bcd_field_codec: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/arbcd_pkg.sv
rtl/arbcd_if.sv
rtl/arbcd_front.sv
rtl/arbcd_digits.sv
rtl/arinc429_bcd_field_codec.sv
test/tb_arinc429_bcd_field_codec.sv
